### sv/kvr_pkg.sv
`timescale 1ns / 1ps

package kvr_pkg;

  // Default number of fraction bits of the signed fixed-point values.
  localparam int unsigned FracBits = 12;

  localparam int unsigned StepW  = 13;
  localparam int unsigned LimitW = 4;
  localparam int unsigned GainW  = 15;
  localparam int unsigned OutW   = 16;
  localparam int unsigned IdleW  = 5;

  localparam logic [GainW-1:0] GainMax = '1;
  localparam logic [IdleW-1:0] IdleSat = '1;

  // Key bytes that mean something to the block.
  localparam logic [7:0] KeyFwd       = 8'h69;  // i
  localparam logic [7:0] KeyFwdRight  = 8'h6F;  // o
  localparam logic [7:0] KeyLeft      = 8'h6A;  // j
  localparam logic [7:0] KeyRight     = 8'h6C;  // l
  localparam logic [7:0] KeyFwdLeft   = 8'h75;  // u
  localparam logic [7:0] KeyBack      = 8'h2C;  // ,
  localparam logic [7:0] KeyBackLeft  = 8'h2E;  // .
  localparam logic [7:0] KeyBackRight = 8'h6D;  // m
  localparam logic [7:0] KeyBothUp    = 8'h71;  // q
  localparam logic [7:0] KeyBothDown  = 8'h7A;  // z
  localparam logic [7:0] KeySpeedUp   = 8'h77;  // w
  localparam logic [7:0] KeySpeedDown = 8'h78;  // x
  localparam logic [7:0] KeyTurnUp    = 8'h65;  // e
  localparam logic [7:0] KeyTurnDown  = 8'h63;  // c
  localparam logic [7:0] KeySpace     = 8'h20;
  localparam logic [7:0] KeyStop      = 8'h6B;  // k
  localparam logic [7:0] KeyHalt      = 8'h03;

  // Reciprocal of ten: floor(v * 838861 / 2^23) equals floor(v / 10) for v below 2^21.
  localparam logic [19:0] RecipTen      = 20'd838861;
  localparam int unsigned RecipTenShift = 23;

  typedef enum logic [1:0] {
    REG_LINEAR_STEP = 2'd0,
    REG_TURN_STEP   = 2'd1,
    REG_IDLE_LIMIT  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_DIR,
    KIND_SCALE,
    KIND_STOP,
    KIND_UNKNOWN,
    KIND_HALT
  } key_kind_e;

  typedef enum logic [1:0] {
    SCALE_KEEP,
    SCALE_UP,
    SCALE_DOWN
  } scale_e;

  typedef logic signed [1:0] sign_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       taken_by_arm;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] linear_speed;
    logic signed [OutW-1:0] angular_rate;
  } out_item_t;

  typedef struct packed {
    logic [StepW-1:0]  linear_step;
    logic [StepW-1:0]  turn_step;
    logic [LimitW-1:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    key_kind_e kind;
    sign_t     lin_sign;
    sign_t     turn_sign;
    scale_e    speed_scale;
    scale_e    turn_scale;
  } key_dec_t;

  // Gain times 1.1 or 0.9, rounded half up, limited to the largest gain.
  function automatic logic [GainW-1:0] scale_gain(input logic [GainW-1:0] gain,
                                                 input scale_e code);
    logic [18:0] num;
    logic [38:0] prod;
    logic [15:0] quot;
    logic [GainW-1:0] res;
    num  = '0;
    prod = '0;
    quot = '0;
    res  = gain;
    case (code)
      SCALE_UP: begin
        num = ({4'd0, gain} << 3) + ({4'd0, gain} << 1) + {4'd0, gain} + 19'd5;
      end
      SCALE_DOWN: begin
        num = ({4'd0, gain} << 3) + {4'd0, gain} + 19'd5;
      end
      default: begin
        num = '0;
      end
    endcase
    if (code == SCALE_UP || code == SCALE_DOWN) begin
      prod = {20'd0, num} * {19'd0, RecipTen};
      quot = prod[RecipTenShift +: 16];
      res  = quot[15] ? GainMax : quot[GainW-1:0];
    end
    return res;
  endfunction

  // Move an output towards its target by at most one step.
  function automatic logic signed [OutW-1:0] slew(input logic signed [OutW-1:0] cur,
                                                 input logic signed [OutW:0]   target,
                                                 input logic [StepW-1:0]      step);
    logic signed [OutW+1:0] o;
    logic signed [OutW+1:0] t;
    logic signed [OutW+1:0] s;
    logic signed [OutW+1:0] up;
    logic signed [OutW+1:0] dn;
    logic signed [OutW+1:0] res;
    o  = {{2{cur[OutW-1]}}, cur};
    t  = {target[OutW], target};
    s  = $signed({5'd0, step});
    up = o + s;
    dn = o - s;
    if (t > o) begin
      res = (up < t) ? up : t;
    end else if (t < o) begin
      res = (dn > t) ? dn : t;
    end else begin
      res = t;
    end
    return res[OutW-1:0];
  endfunction

endpackage

### sv/kvr_key_decode.sv
`timescale 1ns / 1ps

module kvr_key_decode (
  input  logic [7:0]        key_code_i,
  output kvr_pkg::key_dec_t dec_o
);
  import kvr_pkg::*;

  // Sorts a key byte into its class and the signs or scale codes it carries.
  always_comb begin
    dec_o.kind        = KIND_UNKNOWN;
    dec_o.lin_sign    = 2'sd0;
    dec_o.turn_sign   = 2'sd0;
    dec_o.speed_scale = SCALE_KEEP;
    dec_o.turn_scale  = SCALE_KEEP;
    case (key_code_i)
      KeyFwd: begin
        dec_o.kind     = KIND_DIR;
        dec_o.lin_sign = 2'sd1;
      end
      KeyFwdRight: begin
        dec_o.kind      = KIND_DIR;
        dec_o.lin_sign  = 2'sd1;
        dec_o.turn_sign = -2'sd1;
      end
      KeyLeft: begin
        dec_o.kind      = KIND_DIR;
        dec_o.turn_sign = 2'sd1;
      end
      KeyRight: begin
        dec_o.kind      = KIND_DIR;
        dec_o.turn_sign = -2'sd1;
      end
      KeyFwdLeft: begin
        dec_o.kind      = KIND_DIR;
        dec_o.lin_sign  = 2'sd1;
        dec_o.turn_sign = 2'sd1;
      end
      KeyBack: begin
        dec_o.kind     = KIND_DIR;
        dec_o.lin_sign = -2'sd1;
      end
      KeyBackLeft: begin
        dec_o.kind      = KIND_DIR;
        dec_o.lin_sign  = -2'sd1;
        dec_o.turn_sign = 2'sd1;
      end
      KeyBackRight: begin
        dec_o.kind      = KIND_DIR;
        dec_o.lin_sign  = -2'sd1;
        dec_o.turn_sign = -2'sd1;
      end
      KeyBothUp: begin
        dec_o.kind        = KIND_SCALE;
        dec_o.speed_scale = SCALE_UP;
        dec_o.turn_scale  = SCALE_UP;
      end
      KeyBothDown: begin
        dec_o.kind        = KIND_SCALE;
        dec_o.speed_scale = SCALE_DOWN;
        dec_o.turn_scale  = SCALE_DOWN;
      end
      KeySpeedUp: begin
        dec_o.kind        = KIND_SCALE;
        dec_o.speed_scale = SCALE_UP;
      end
      KeySpeedDown: begin
        dec_o.kind        = KIND_SCALE;
        dec_o.speed_scale = SCALE_DOWN;
      end
      KeyTurnUp: begin
        dec_o.kind       = KIND_SCALE;
        dec_o.turn_scale = SCALE_UP;
      end
      KeyTurnDown: begin
        dec_o.kind       = KIND_SCALE;
        dec_o.turn_scale = SCALE_DOWN;
      end
      KeySpace, KeyStop: begin
        dec_o.kind = KIND_STOP;
      end
      KeyHalt: begin
        dec_o.kind = KIND_HALT;
      end
      default: begin
        dec_o.kind = KIND_UNKNOWN;
      end
    endcase
  end

endmodule

### sv/kvr_cfg_regs.sv
`timescale 1ns / 1ps

module kvr_cfg_regs #(
  parameter int unsigned FRAC_BITS = kvr_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output kvr_pkg::cfg_t cfg_o
);
  import kvr_pkg::*;

  localparam int unsigned OneQ = 1 << FRAC_BITS;
  localparam logic [StepW-1:0] LinearStepRst = StepW'((OneQ * 2 + 50) / 100);
  localparam logic [StepW-1:0] TurnStepRst   = StepW'((OneQ + 5) / 10);
  localparam logic [LimitW-1:0] IdleLimitRst = LimitW'(4);

  logic [StepW-1:0]  linear_step_q;
  logic [StepW-1:0]  turn_step_q;
  logic [LimitW-1:0] idle_limit_q;
  logic              wr_en;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_step_q <= LinearStepRst;
      turn_step_q   <= TurnStepRst;
      idle_limit_q  <= IdleLimitRst;
    end else if (wr_en) begin
      case (idx)
        REG_LINEAR_STEP: linear_step_q <= pwdata[StepW-1:0];
        REG_TURN_STEP:   turn_step_q   <= pwdata[StepW-1:0];
        REG_IDLE_LIMIT:  idle_limit_q  <= pwdata[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINEAR_STEP: prdata = {{(32 - StepW){1'b0}}, linear_step_q};
      REG_TURN_STEP:   prdata = {{(32 - StepW){1'b0}}, turn_step_q};
      REG_IDLE_LIMIT:  prdata = {{(32 - LimitW){1'b0}}, idle_limit_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.linear_step = linear_step_q;
  assign cfg_o.turn_step   = turn_step_q;
  assign cfg_o.idle_limit  = idle_limit_q;

endmodule

### sv/kvr_ramp.sv
`timescale 1ns / 1ps

module kvr_ramp #(
  parameter int unsigned FRAC_BITS = kvr_pkg::FracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvr_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  logic              taken_i,
  input  kvr_pkg::key_dec_t dec_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kvr_pkg::out_item_t out_data_o
);
  import kvr_pkg::*;

  localparam int unsigned OneQ = 1 << FRAC_BITS;
  localparam logic [GainW-1:0] SpeedGainRst = GainW'((OneQ * 2 + 5) / 10);
  localparam logic [GainW-1:0] TurnGainRst  = GainW'(OneQ);

  sign_t                  lin_sign_q, lin_sign_d;
  sign_t                  turn_sign_q, turn_sign_d;
  logic [GainW-1:0]       speed_gain_q, speed_gain_d;
  logic [GainW-1:0]       turn_gain_q, turn_gain_d;
  logic [IdleW-1:0]       idle_cnt_q, idle_cnt_d;
  logic signed [OutW-1:0] lin_out_q, lin_out_d;
  logic signed [OutW-1:0] turn_out_q, turn_out_d;
  logic                   halted_q, halted_d;
  logic                   res_valid_q, res_valid_d;

  logic                   work;
  logic signed [OutW-1:0] lin_base, turn_base;
  logic signed [OutW:0]   lin_target, turn_target;

  // The output state doubles as the result register: it only changes when the
  // previous result has been taken or is being taken in this cycle.
  assign advance_o = item_valid_i && (!res_valid_q || !out_stall_i);
  assign work      = advance_o && !halted_q && !taken_i;

  always_comb begin
    lin_sign_d   = lin_sign_q;
    turn_sign_d  = turn_sign_q;
    speed_gain_d = speed_gain_q;
    turn_gain_d  = turn_gain_q;
    idle_cnt_d   = idle_cnt_q;
    halted_d     = halted_q;
    lin_base     = lin_out_q;
    turn_base    = turn_out_q;
    res_valid_d  = res_valid_q && out_stall_i;

    if (work) begin
      case (dec_i.kind)
        KIND_DIR: begin
          lin_sign_d  = dec_i.lin_sign;
          turn_sign_d = dec_i.turn_sign;
          idle_cnt_d  = '0;
        end
        KIND_SCALE: begin
          speed_gain_d = scale_gain(speed_gain_q, dec_i.speed_scale);
          turn_gain_d  = scale_gain(turn_gain_q, dec_i.turn_scale);
          idle_cnt_d   = '0;
        end
        KIND_STOP: begin
          lin_sign_d  = 2'sd0;
          turn_sign_d = 2'sd0;
          lin_base    = '0;
          turn_base   = '0;
        end
        default: begin
          if (idle_cnt_q != IdleSat) begin
            idle_cnt_d = idle_cnt_q + IdleW'(1);
          end
          if (idle_cnt_d > {1'b0, cfg_i.idle_limit}) begin
            lin_sign_d  = 2'sd0;
            turn_sign_d = 2'sd0;
          end
          if (dec_i.kind == KIND_HALT) begin
            halted_d = 1'b1;
          end
        end
      endcase
      if (dec_i.kind != KIND_HALT) begin
        res_valid_d = 1'b1;
      end
    end
  end

  always_comb begin
    case (lin_sign_d)
      2'sd1:   lin_target = $signed({2'b00, speed_gain_d});
      -2'sd1:  lin_target = -$signed({2'b00, speed_gain_d});
      default: lin_target = '0;
    endcase
    case (turn_sign_d)
      2'sd1:   turn_target = $signed({2'b00, turn_gain_d});
      -2'sd1:  turn_target = -$signed({2'b00, turn_gain_d});
      default: turn_target = '0;
    endcase
  end

  always_comb begin
    lin_out_d  = lin_out_q;
    turn_out_d = turn_out_q;
    if (work && dec_i.kind != KIND_HALT) begin
      lin_out_d  = slew(lin_base, lin_target, cfg_i.linear_step);
      turn_out_d = slew(turn_base, turn_target, cfg_i.turn_step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_sign_q   <= 2'sd0;
      turn_sign_q  <= 2'sd0;
      speed_gain_q <= SpeedGainRst;
      turn_gain_q  <= TurnGainRst;
      idle_cnt_q   <= '0;
      lin_out_q    <= '0;
      turn_out_q   <= '0;
      halted_q     <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      lin_sign_q   <= lin_sign_d;
      turn_sign_q  <= turn_sign_d;
      speed_gain_q <= speed_gain_d;
      turn_gain_q  <= turn_gain_d;
      idle_cnt_q   <= idle_cnt_d;
      lin_out_q    <= lin_out_d;
      turn_out_q   <= turn_out_d;
      halted_q     <= halted_d;
      res_valid_q  <= res_valid_d;
    end
  end

  assign out_valid_o             = res_valid_q;
  assign out_data_o.linear_speed = lin_out_q;
  assign out_data_o.angular_rate = turn_out_q;

  // Once halted the block stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halted state was left without reset");

  // A halted block never produces another result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && !res_valid_q) |=> !res_valid_q)
    else $error("result produced while halted");

  // A stop key zeroes both outputs in the same step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && dec_i.kind == KIND_STOP) |=> (lin_out_q == 0 && turn_out_q == 0))
    else $error("stop key did not clear the outputs");

  // Signs only take the values -1, 0 and +1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lin_sign_q != -2'sd2) && (turn_sign_q != -2'sd2))
    else $error("motion sign out of range");

  // The output state must not move while a result is held by a stalled consumer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_stall_i) |=> ($stable(lin_out_q) && $stable(turn_out_q)))
    else $error("held result overwritten");

endmodule

### sv/key_teleop_velocity_ramp_core.sv
`timescale 1ns / 1ps

// Keyboard teleoperation velocity ramp. Each input transfer carries one key
// byte and a flag that marks keys already consumed by the arm handler; such
// keys, and every key after the halt key (0x03), produce no output transfer
// and leave the state untouched. Direction keys set the linear and turn signs,
// scale keys change the speed and turn gains by 1.1 or 0.9 (rounded, limited
// to 32767), space or k stops both outputs at once, and too many unknown keys
// in a row clear both signs. Every other key produces one output transfer in
// which both signed fixed-point outputs have moved towards gain times sign by
// at most the programmed step. The block takes one item per clock cycle while
// the input side is not stalled: an item is held in the input register, and the
// decode, gain scaling and slew logic update the state and the output register
// from it when it moves on. The input side stalls only while an item waits
// behind an output transfer that the consumer is stalling. The step and idle
// limit registers are written over the APB port at byte addresses 0x0, 0x4 and
// 0x8 and must only be changed while the block is idle.
module key_teleop_velocity_ramp_core #(
  parameter int unsigned FRAC_BITS = kvr_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kvr_pkg::in_item_t  in_data_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kvr_pkg::out_item_t out_data_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kvr_pkg::*;

  cfg_t     cfg;
  key_dec_t dec;
  in_item_t item_q;
  logic     item_valid_q;
  logic     advance;

  // The input register is free when it is empty or its item moves on now.
  assign in_stall_o = item_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; it is qualified by the valid bit.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  kvr_cfg_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  kvr_key_decode u_decode (
    .key_code_i(item_q.key_code),
    .dec_o     (dec)
  );

  kvr_ramp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(item_valid_q),
    .taken_i     (item_q.taken_by_arm),
    .dec_i       (dec),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
